@@ src/fdc_pkg.sv @@
// Package for the framed delta coder: configuration types, register and operation codes,
// and the lane-aware add/subtract shared by the datapath.
// No dependencies.
package fdc_pkg;

   // Widths fixed by the register map and the stream fields.
   localparam int unsigned DATA_WIDTH      = 32;
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned U8_BITS         = 8;

   // Register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OPERATION      = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ELEMENT_BYTES  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FRAME_ELEMENTS = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BYTE_LANES     = 2'd3;

   // Operation codes.
   localparam logic [1:0] OP_DIFF        = 2'd0;
   localparam logic [1:0] OP_SUM         = 2'd1;
   localparam logic [1:0] OP_SECOND_DIFF = 2'd2;
   localparam logic [1:0] OP_DOUBLE_SUM  = 2'd3;

   // Register reset values.
   localparam logic [DATA_WIDTH-1:0] FRAME_ELEMENTS_RESET = 32'd1;

   typedef struct packed {
      logic [1:0]            operation;
      logic [1:0]            element_bytes_less_one;
      logic [DATA_WIDTH-1:0] frame_elements_less_one;
      logic                  per_byte_lanes;
   } cfg_type;

   // a + b or a - b, either across the whole word or with each byte wrapping on its own.
   function automatic logic [DATA_WIDTH-1:0] lane_combine(
      input logic [DATA_WIDTH-1:0] a,
      input logic [DATA_WIDTH-1:0] b,
      input logic                  sub,
      input logic                  lanes
   );
      logic [DATA_WIDTH-1:0] whole;
      logic [DATA_WIDTH-1:0] split;
      whole = sub ? (a - b) : (a + b);
      for (int i = 0; i < DATA_WIDTH / U8_BITS; i++) begin
         split[i*U8_BITS +: U8_BITS] = sub ? (a[i*U8_BITS +: U8_BITS] - b[i*U8_BITS +: U8_BITS])
                                           : (a[i*U8_BITS +: U8_BITS] + b[i*U8_BITS +: U8_BITS]);
      end
      return lanes ? split : whole;
   endfunction

endpackage

@@ src/fdc_csr.sv @@
// Configuration registers of the framed delta coder, written through a plain write port.
// Depends on fdc_pkg.
module fdc_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [fdc_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [fdc_pkg::DATA_WIDTH-1:0]       csr_write_data,
   output fdc_pkg::cfg_type                     cfg
);

   fdc_pkg::cfg_type cfg_ff;
   fdc_pkg::cfg_type cfg_in;

   // Decode the write and update the addressed field only.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            fdc_pkg::CSR_OPERATION:      cfg_in.operation = csr_write_data[1:0];
            fdc_pkg::CSR_ELEMENT_BYTES:  cfg_in.element_bytes_less_one = csr_write_data[1:0];
            fdc_pkg::CSR_FRAME_ELEMENTS: cfg_in.frame_elements_less_one = csr_write_data;
            fdc_pkg::CSR_BYTE_LANES:     cfg_in.per_byte_lanes = csr_write_data[0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.operation               <= fdc_pkg::OP_DIFF;
         cfg_ff.element_bytes_less_one  <= 2'd0;
         cfg_ff.frame_elements_less_one <= fdc_pkg::FRAME_ELEMENTS_RESET;
         cfg_ff.per_byte_lanes          <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ src/fdc_datapath.sv @@
// Coding datapath: history registers, frame position counter and the add/subtract logic
// that turns one registered element into one result. Depends on fdc_pkg.
module fdc_datapath #(
   parameter int unsigned MAX_ELEMENT_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  fdc_pkg::cfg_type             cfg,
   input  logic                         step,
   input  logic [MAX_ELEMENT_WIDTH-1:0] element,
   output logic [MAX_ELEMENT_WIDTH-1:0] result,
   output logic                         last
);

   localparam int unsigned DW = fdc_pkg::DATA_WIDTH;

   logic [MAX_ELEMENT_WIDTH-1:0] first_history_ff,  first_history_in;
   logic [MAX_ELEMENT_WIDTH-1:0] second_history_ff, second_history_in;
   logic [DW-1:0]                position_ff,       position_in;

   logic [5:0]                   width_bits;
   logic [5:0]                   elem_bits;
   logic [MAX_ELEMENT_WIDTH-1:0] mask;
   logic [MAX_ELEMENT_WIDTH-1:0] x;
   logic [MAX_ELEMENT_WIDTH-1:0] h1;
   logic [MAX_ELEMENT_WIDTH-1:0] h2;
   logic [MAX_ELEMENT_WIDTH-1:0] first_term;
   logic [MAX_ELEMENT_WIDTH-1:0] second_term;
   logic                         start;
   logic                         subtract;

   // Element width in bits, limited by the widest element the block carries.
   always_comb begin
      width_bits = {2'b00, cfg.element_bytes_less_one, 2'b00} + 6'd4;
      width_bits = {width_bits[4:0], 1'b0};
      elem_bits  = (width_bits > 6'(MAX_ELEMENT_WIDTH)) ? 6'(MAX_ELEMENT_WIDTH) : width_bits;
      for (int i = 0; i < MAX_ELEMENT_WIDTH; i++) begin
         mask[i] = (6'(i) < elem_bits);
      end
   end

   // Operands, masked to the current width.
   assign x        = element & mask;
   assign h1       = first_history_ff & mask;
   assign h2       = second_history_ff & mask;
   assign start    = (position_ff == '0);
   assign subtract = (cfg.operation == fdc_pkg::OP_DIFF) ||
                     (cfg.operation == fdc_pkg::OP_SECOND_DIFF);

   // First stage of the arithmetic: against the previous element, or nothing at frame start.
   assign first_term = MAX_ELEMENT_WIDTH'(fdc_pkg::lane_combine(
                          DW'(x), DW'(start ? '0 : h1), subtract, cfg.per_byte_lanes)) & mask;

   // Second stage, used by the second-order operations past the frame start.
   assign second_term = MAX_ELEMENT_WIDTH'(fdc_pkg::lane_combine(
                           DW'(first_term), DW'(h2), subtract, cfg.per_byte_lanes)) & mask;

   assign result = (cfg.operation[1] && !start) ? second_term : first_term;
   assign last   = (position_ff >= cfg.frame_elements_less_one);

   // History and position updates for the element being coded.
   always_comb begin
      first_history_in  = first_history_ff;
      second_history_in = second_history_ff;
      case (cfg.operation)
         fdc_pkg::OP_DIFF: begin
            first_history_in = x;
         end
         fdc_pkg::OP_SUM: begin
            first_history_in = first_term;
         end
         fdc_pkg::OP_SECOND_DIFF: begin
            first_history_in  = x;
            second_history_in = start ? '0 : first_term;
         end
         default: begin
            first_history_in  = start ? '0 : first_term;
            second_history_in = start ? first_term : second_term;
         end
      endcase
      position_in = last ? '0 : position_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_history_ff  <= '0;
         second_history_ff <= '0;
         position_ff       <= '0;
      end else if (step) begin
         first_history_ff  <= first_history_in;
         second_history_ff <= second_history_in;
         position_ff       <= position_in;
      end
   end

   // A coded element never carries bits above the element width.
   assert property (@(posedge clock) disable iff (reset) step |-> ((result & ~mask) == '0))
      else $error("result has bits above the element width");

   // The last element of a frame sends the position back to the start.
   assert property (@(posedge clock) disable iff (reset) (step && last) |=> (position_ff == '0))
      else $error("position not cleared after the last element of a frame");

   // Any other element moves the position on by one.
   assert property (@(posedge clock) disable iff (reset)
                    (step && !last) |=> (position_ff == $past(position_ff) + 1'b1))
      else $error("position did not advance by one");

endmodule

@@ src/framed_delta_coder_core.sv @@
// Top level of the framed delta coder: request register, coding datapath, response register.
// Depends on fdc_pkg, fdc_csr and fdc_datapath.
//
// Usage:
//   Elements enter on the request channel (req_valid/req_ready, req_element_value) and
//   one coded element leaves on the response channel for each request
//   (rsp_valid/rsp_ready, rsp_result_value, rsp_frame_last marks the end of a frame).
//   Configuration is written through csr_write_enable/csr_index/csr_write_data while
//   no request is in flight; new values apply from the next element.
// Flow and throughput:
//   A request accepted into the request register is coded from it combinationally, and the
//   result is captured in the response register, which drives the response port.
//   One request is accepted every cycle while the response is not stalled.
// Reset:
//   Synchronous reset empties both registers, clears the histories and the frame
//   position, and loads the register reset values.
// Stalls:
//   While rsp_ready is low the response holds; one further request is still taken into
//   the request register, after which req_ready drops until the response moves on.
module framed_delta_coder_core #(
   parameter int unsigned MAX_ELEMENT_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [fdc_pkg::DATA_WIDTH-1:0]      req_element_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [fdc_pkg::DATA_WIDTH-1:0]      rsp_result_value,
   output logic                                rsp_frame_last,
   input  logic                                csr_write_enable,
   input  logic [fdc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [fdc_pkg::DATA_WIDTH-1:0]      csr_write_data
);

   fdc_pkg::cfg_type cfg;

   logic                         in_valid_ff,  in_valid_in;
   logic [MAX_ELEMENT_WIDTH-1:0] in_elem_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [MAX_ELEMENT_WIDTH-1:0] rsp_value_ff;
   logic                         rsp_last_ff;

   logic                         advance;
   logic                         req_take;
   logic [MAX_ELEMENT_WIDTH-1:0] coded;
   logic                         coded_last;

   fdc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   fdc_datapath #(
      .MAX_ELEMENT_WIDTH (MAX_ELEMENT_WIDTH)
   ) u_datapath (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .step    (advance),
      .element (in_elem_ff),
      .result  (coded),
      .last    (coded_last)
   );

   // The request register moves into the response register whenever that one is free.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      rsp_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   // Handshake state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_elem_ff <= MAX_ELEMENT_WIDTH'(req_element_value);
      end
      if (advance) begin
         rsp_value_ff <= coded;
         rsp_last_ff  <= coded_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = fdc_pkg::DATA_WIDTH'(rsp_value_ff);
   assign rsp_frame_last   = rsp_last_ff;

   // An empty request register always takes a request.
   assert property (@(posedge clock) disable iff (reset) !in_valid_ff |-> req_ready)
      else $error("request refused while the request register is empty");

   // A held request is not dropped while the response stalls.
   assert property (@(posedge clock) disable iff (reset)
                    (in_valid_ff && rsp_valid_ff && !rsp_ready) |=> (in_valid_ff && rsp_valid_ff))
      else $error("request or response lost during a stall");

endmodule
